// ----- sv/rflg_pkg.sv -----
package rflg_pkg;

    // Phase table resolution of the wave shaping.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

    localparam logic [2:0] CTRL_RESET = 3'd2;

    // Commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ON     = 3'd1;
    localparam logic [2:0] CMD_OFF    = 3'd2;
    localparam logic [2:0] CMD_LOCK   = 3'd3;
    localparam logic [2:0] CMD_UNLOCK = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_LEVEL_MIN    = 3'd0;
    localparam logic [2:0] CFG_LEVEL_MAX    = 3'd1;
    localparam logic [2:0] CFG_LEVEL_PER    = 3'd2;
    localparam logic [2:0] CFG_IVL_MIN      = 3'd3;
    localparam logic [2:0] CFG_IVL_MAX      = 3'd4;
    localparam logic [2:0] CFG_IVL_PER      = 3'd5;
    localparam logic [2:0] CFG_WAVE_MODES   = 3'd6;
    localparam logic [2:0] CFG_CTRL_FLAGS   = 3'd7;

    // Wave shapes
    localparam logic [1:0] WAVE_NONE   = 2'd0;
    localparam logic [1:0] WAVE_COS    = 2'd1;
    localparam logic [1:0] WAVE_SIN    = 2'd2;
    localparam logic [1:0] WAVE_SQUARE = 2'd3;

    // Datapath operations
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_LATCH     = 5'd1;
    localparam logic [4:0] OP_TICK      = 5'd2;
    localparam logic [4:0] OP_SHIFT     = 5'd3;
    localparam logic [4:0] OP_MOD_START = 5'd4;
    localparam logic [4:0] OP_IDX_START = 5'd5;
    localparam logic [4:0] OP_PHASE     = 5'd6;
    localparam logic [4:0] OP_SQ1       = 5'd7;
    localparam logic [4:0] OP_SQ2       = 5'd8;
    localparam logic [4:0] OP_SQ3       = 5'd9;
    localparam logic [4:0] OP_AC1       = 5'd10;
    localparam logic [4:0] OP_AC2       = 5'd11;
    localparam logic [4:0] OP_AC3       = 5'd12;
    localparam logic [4:0] OP_WEIGHT    = 5'd13;
    localparam logic [4:0] OP_SCALE     = 5'd14;
    localparam logic [4:0] OP_PROD      = 5'd15;
    localparam logic [4:0] OP_DRAW_END  = 5'd16;
    localparam logic [4:0] OP_INT_DIRECT= 5'd17;
    localparam logic [4:0] OP_IN1       = 5'd18;
    localparam logic [4:0] OP_IN2       = 5'd19;
    localparam logic [4:0] OP_INT_START = 5'd20;
    localparam logic [4:0] OP_INT_END   = 5'd21;
    localparam logic [4:0] OP_ON        = 5'd22;
    localparam logic [4:0] OP_OFF       = 5'd23;
    localparam logic [4:0] OP_LOCK      = 5'd24;
    localparam logic [4:0] OP_UNLOCK    = 5'd25;
    localparam logic [4:0] OP_EMIT      = 5'd26;

    typedef struct packed {
        logic [4:0] op;
        logic       which;    // 0 level draw, 1 interval draw
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       enabled;
        logic       locked;
        logic       expired;
        logic       interp;
        logic       len_zero;
        logic       suppress;
        logic       div_busy;
        logic       div_done;
        logic       out_free;
    } t_dp_stat;

endpackage

// ----- sv/rflg_in_if.sv -----
interface rflg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [9:0]  frame_ms;
    logic [15:0] level_random;
    logic [15:0] interval_random;

    modport source (output valid, command, frame_ms, level_random, interval_random,
                    input ready);
    modport sink   (input valid, command, frame_ms, level_random, interval_random,
                    output ready);
endinterface

// ----- sv/rflg_out_if.sv -----
interface rflg_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] intensity;

    modport source (output valid, intensity, input ready);
    modport sink   (input valid, intensity, output ready);
endinterface

// ----- sv/rflg_div.sv -----
module rflg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic [31:0] o_quo,
    output logic [15:0] o_rem,
    output logic        o_busy,
    output logic        o_done
);
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign ge    = trial >= {1'b0, r_den};

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

// ----- sv/rflg_datapath.sv -----
module rflg_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rflg_pkg::t_dp_cmd  i_cmd,
    output rflg_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [2:0]         i_command,
    input  logic [9:0]         i_frame_ms,
    input  logic [15:0]        i_level_random,
    input  logic [15:0]        i_interval_random,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_intensity
);
    localparam int IW = rflg_pkg::IDX_W;

    // configuration
    logic [15:0] r_lvl_min, r_lvl_max, r_lvl_per, r_ivl_min, r_ivl_max, r_ivl_per;
    logic [3:0]  r_modes;
    logic [2:0]  r_flags;
    // state
    logic [15:0] r_prev, r_cur, r_len;
    logic [16:0] r_countdown;
    logic [31:0] r_elapsed;
    logic        r_enabled, r_locked;
    // latched item
    logic [2:0]  r_cmd;
    logic [9:0]  r_frame;
    logic [15:0] r_lrnd, r_irnd;
    // work registers
    logic [15:0] r_pos;
    logic [14:0] r_x, r_x2, r_x3, r_x5;
    logic [1:0]  r_quad;
    logic [34:0] r_acc;
    logic [15:0] r_w, r_scaled, r_res;
    logic [31:0] r_prod;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // divider
    logic        div_start;
    logic [31:0] div_num, div_quo;
    logic [15:0] div_den, div_rem;
    logic        div_busy, div_done;

    // selected draw operands
    logic [15:0] a, b, lo, hi, range, per, rnd;
    logic [1:0]  mode;
    logic [15:0] t;
    logic [13:0] f;
    logic [29:0] m_sq1, m_sq2, m_sq3, m_ac;
    logic [19:0] s_sh;
    logic [14:0] s;
    logic [31:0] m_scale, m_prod;
    logic [15:0] q0;
    logic [16:0] rr;
    logic [15:0] q, val;
    logic [15:0] c;
    logic [31:0] m_in;

    always_comb begin
        a    = i_cmd.which ? r_ivl_min : r_lvl_min;
        b    = i_cmd.which ? r_ivl_max : r_lvl_max;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        range = hi - lo;
        per  = i_cmd.which ? r_ivl_per : r_lvl_per;
        if (per == 16'd0) begin
            per = 16'd1;
        end
        rnd  = i_cmd.which ? r_irnd : r_lrnd;
        mode = i_cmd.which ? r_modes[3:2] : r_modes[1:0];

        t = {div_quo[IW-1:0], {(16-IW){1'b0}}};
        if (mode == rflg_pkg::WAVE_COS) begin
            t = t + 16'h4000;
        end
        f = t[13:0];

        m_sq1 = r_x * r_x;
        m_sq2 = r_x2 * r_x;
        m_sq3 = r_x3 * r_x2;
        m_ac  = 30'(r_x) * 30'd25736;

        s_sh = r_acc[33:14];
        if (r_acc[34] || s_sh > 20'd16384) begin
            s = 15'd16384;
        end else begin
            s = s_sh[14:0];
        end

        m_scale = range * r_w;
        m_prod  = rnd * r_scaled;

        // divide by 65535: one correction step suffices
        q0 = r_prod[31:16];
        rr = {1'b0, r_prod[15:0]} + {1'b0, q0};
        q  = (rr >= 17'd65535) ? q0 + 16'd1 : q0;
        if (mode == rflg_pkg::WAVE_SQUARE) begin
            val = ({r_pos, 1'b0} < {1'b0, per}) ? lo : hi;
        end else begin
            val = lo + q;
        end

        if (r_countdown[16] || r_countdown == 17'd0) begin
            c = 16'd0;
        end else if (r_countdown[15:0] > r_len) begin
            c = r_len;
        end else begin
            c = r_countdown[15:0];
        end
        m_in = r_cur * (r_len - c);

        div_start = 1'b0;
        div_num   = r_elapsed;
        div_den   = per;
        case (i_cmd.op)
            rflg_pkg::OP_MOD_START: begin
                div_start = 1'b1;
            end
            rflg_pkg::OP_IDX_START: begin
                div_start = 1'b1;
                div_num   = 32'({div_rem, {IW{1'b0}}});
            end
            rflg_pkg::OP_INT_START: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = r_len;
            end
            default: begin
            end
        endcase
    end

    rflg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_busy  (div_busy),
        .o_done  (div_done)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_min   <= 16'd0;
            r_lvl_max   <= 16'd65535;
            r_lvl_per   <= 16'd10000;
            r_ivl_min   <= 16'd0;
            r_ivl_max   <= 16'd0;
            r_ivl_per   <= 16'd10000;
            r_modes     <= 4'd0;
            r_flags     <= rflg_pkg::CTRL_RESET;
            r_prev      <= '0;
            r_cur       <= '0;
            r_len       <= '0;
            r_countdown <= '0;
            r_elapsed   <= '0;
            r_enabled   <= rflg_pkg::CTRL_RESET[1];
            r_locked    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rflg_pkg::CFG_LEVEL_MIN:  r_lvl_min <= i_cfg_data;
                    rflg_pkg::CFG_LEVEL_MAX:  r_lvl_max <= i_cfg_data;
                    rflg_pkg::CFG_LEVEL_PER:  r_lvl_per <= i_cfg_data;
                    rflg_pkg::CFG_IVL_MIN:    r_ivl_min <= i_cfg_data;
                    rflg_pkg::CFG_IVL_MAX:    r_ivl_max <= i_cfg_data;
                    rflg_pkg::CFG_IVL_PER:    r_ivl_per <= i_cfg_data;
                    rflg_pkg::CFG_WAVE_MODES: r_modes   <= i_cfg_data[3:0];
                    rflg_pkg::CFG_CTRL_FLAGS: r_flags   <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                rflg_pkg::OP_TICK: begin
                    r_elapsed   <= r_elapsed + 32'(r_frame);
                    r_countdown <= r_countdown - 17'(r_frame);
                end
                rflg_pkg::OP_SHIFT: r_prev <= r_cur;
                rflg_pkg::OP_DRAW_END: begin
                    if (i_cmd.which) begin
                        r_len       <= val;
                        r_countdown <= {1'b0, val};
                    end else begin
                        r_cur <= val;
                    end
                end
                rflg_pkg::OP_ON:     r_enabled <= 1'b1;
                rflg_pkg::OP_OFF:    r_enabled <= 1'b0;
                rflg_pkg::OP_LOCK:   r_locked  <= 1'b1;
                rflg_pkg::OP_UNLOCK: r_locked  <= 1'b0;
                rflg_pkg::OP_EMIT:   r_out_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rflg_pkg::OP_LATCH: begin
                r_cmd   <= i_command;
                r_frame <= i_frame_ms;
                r_lrnd  <= i_level_random;
                r_irnd  <= i_interval_random;
            end
            rflg_pkg::OP_IDX_START: r_pos <= div_rem;
            rflg_pkg::OP_PHASE: begin
                r_quad <= t[15:14];
                r_x    <= t[14] ? 15'(15'd16384 - {1'b0, f}) : {1'b0, f};
            end
            rflg_pkg::OP_SQ1:  r_x2 <= m_sq1[28:14];
            rflg_pkg::OP_SQ2:  r_x3 <= m_sq2[28:14];
            rflg_pkg::OP_SQ3:  r_x5 <= m_sq3[28:14];
            rflg_pkg::OP_AC1:  r_acc <= 35'(m_ac);
            rflg_pkg::OP_AC2:  r_acc <= r_acc + 35'(r_x5 * 26'd1232);
            rflg_pkg::OP_AC3:  r_acc <= r_acc - 35'(r_x3 * 29'd10584);
            rflg_pkg::OP_WEIGHT: begin
                r_w <= r_quad[1] ? 16'(16'd16384 - {1'b0, s}) : 16'(16'd16384 + {1'b0, s});
            end
            rflg_pkg::OP_SCALE: begin
                r_scaled <= (mode == rflg_pkg::WAVE_NONE) ? range : m_scale[30:15];
            end
            rflg_pkg::OP_PROD:  r_prod <= m_prod;
            rflg_pkg::OP_INT_DIRECT: r_res <= r_flags[0] ? r_prev : r_cur;
            rflg_pkg::OP_IN1:   r_prod <= r_prev * c;
            rflg_pkg::OP_IN2:   r_prod <= r_prod + m_in;
            rflg_pkg::OP_INT_END: r_res <= div_quo[15:0];
            rflg_pkg::OP_OFF:   r_res <= 16'hFFFF;
            rflg_pkg::OP_EMIT:  r_out_data <= r_res;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.enabled  = r_enabled;
        o_stat.locked   = r_locked;
        o_stat.expired  = r_countdown[16] || (r_countdown == 17'd0);
        o_stat.interp   = r_flags[0];
        o_stat.len_zero = (r_len == 16'd0);
        o_stat.suppress = r_locked || r_flags[2];
        o_stat.div_busy = div_busy;
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_intensity = r_out_data;
endmodule

// ----- sv/rflg_ctrl.sv -----
module rflg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  rflg_pkg::t_dp_stat i_stat,
    output rflg_pkg::t_dp_cmd  o_cmd,
    output logic               o_in_ready
);
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_TICK_CHK = 5'd2;
    localparam logic [4:0] S_MOD_ST   = 5'd3;
    localparam logic [4:0] S_MOD_W    = 5'd4;
    localparam logic [4:0] S_IDX_ST   = 5'd5;
    localparam logic [4:0] S_IDX_W    = 5'd6;
    localparam logic [4:0] S_PHASE    = 5'd7;
    localparam logic [4:0] S_SQ1      = 5'd8;
    localparam logic [4:0] S_SQ2      = 5'd9;
    localparam logic [4:0] S_SQ3      = 5'd10;
    localparam logic [4:0] S_AC1      = 5'd11;
    localparam logic [4:0] S_AC2      = 5'd12;
    localparam logic [4:0] S_AC3      = 5'd13;
    localparam logic [4:0] S_WEIGHT   = 5'd14;
    localparam logic [4:0] S_SCALE    = 5'd15;
    localparam logic [4:0] S_PROD     = 5'd16;
    localparam logic [4:0] S_DRAW_END = 5'd17;
    localparam logic [4:0] S_INT_A    = 5'd18;
    localparam logic [4:0] S_IN1      = 5'd19;
    localparam logic [4:0] S_IN2      = 5'd20;
    localparam logic [4:0] S_INT_ST   = 5'd21;
    localparam logic [4:0] S_INT_W    = 5'd22;
    localparam logic [4:0] S_INT_END  = 5'd23;
    localparam logic [4:0] S_EMIT     = 5'd24;

    logic [4:0] r_state, n_state;
    logic       r_which, n_which;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_which <= 1'b0;
        end else begin
            r_state <= n_state;
            r_which <= n_which;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_which     = r_which;
        o_cmd.op    = rflg_pkg::OP_NONE;
        o_cmd.which = r_which;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.op = rflg_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.cmd)
                    rflg_pkg::CMD_TICK: begin
                        if (i_stat.enabled) begin
                            o_cmd.op = rflg_pkg::OP_TICK;
                            n_state  = S_TICK_CHK;
                        end
                    end
                    rflg_pkg::CMD_ON: begin
                        if (!i_stat.enabled) begin
                            o_cmd.op = rflg_pkg::OP_ON;
                            n_state  = S_INT_A;
                        end
                    end
                    rflg_pkg::CMD_OFF: begin
                        if (i_stat.enabled) begin
                            o_cmd.op = rflg_pkg::OP_OFF;
                            n_state  = S_EMIT;
                        end
                    end
                    rflg_pkg::CMD_LOCK: o_cmd.op = rflg_pkg::OP_LOCK;
                    rflg_pkg::CMD_UNLOCK: begin
                        if (i_stat.locked) begin
                            o_cmd.op = rflg_pkg::OP_UNLOCK;
                            n_state  = i_stat.enabled ? S_INT_A : S_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_TICK_CHK: begin
                if (i_stat.expired) begin
                    o_cmd.op = rflg_pkg::OP_SHIFT;
                    n_which  = 1'b0;
                    n_state  = S_MOD_ST;
                end else if (i_stat.interp) begin
                    n_state = S_INT_A;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MOD_ST: begin
                o_cmd.op = rflg_pkg::OP_MOD_START;
                n_state  = S_MOD_W;
            end
            S_MOD_W:  if (i_stat.div_done) n_state = S_IDX_ST;
            S_IDX_ST: begin
                o_cmd.op = rflg_pkg::OP_IDX_START;
                n_state  = S_IDX_W;
            end
            S_IDX_W:  if (i_stat.div_done) n_state = S_PHASE;
            S_PHASE:  begin o_cmd.op = rflg_pkg::OP_PHASE;  n_state = S_SQ1;    end
            S_SQ1:    begin o_cmd.op = rflg_pkg::OP_SQ1;    n_state = S_SQ2;    end
            S_SQ2:    begin o_cmd.op = rflg_pkg::OP_SQ2;    n_state = S_SQ3;    end
            S_SQ3:    begin o_cmd.op = rflg_pkg::OP_SQ3;    n_state = S_AC1;    end
            S_AC1:    begin o_cmd.op = rflg_pkg::OP_AC1;    n_state = S_AC2;    end
            S_AC2:    begin o_cmd.op = rflg_pkg::OP_AC2;    n_state = S_AC3;    end
            S_AC3:    begin o_cmd.op = rflg_pkg::OP_AC3;    n_state = S_WEIGHT; end
            S_WEIGHT: begin o_cmd.op = rflg_pkg::OP_WEIGHT; n_state = S_SCALE;  end
            S_SCALE:  begin o_cmd.op = rflg_pkg::OP_SCALE;  n_state = S_PROD;   end
            S_PROD:   begin o_cmd.op = rflg_pkg::OP_PROD;   n_state = S_DRAW_END; end
            S_DRAW_END: begin
                o_cmd.op = rflg_pkg::OP_DRAW_END;
                if (!r_which) begin
                    n_which = 1'b1;
                    n_state = S_MOD_ST;
                end else begin
                    n_state = S_INT_A;
                end
            end
            S_INT_A: begin
                if (!i_stat.interp || i_stat.len_zero) begin
                    o_cmd.op = rflg_pkg::OP_INT_DIRECT;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_IN1;
                end
            end
            S_IN1:    begin o_cmd.op = rflg_pkg::OP_IN1;       n_state = S_IN2;    end
            S_IN2:    begin o_cmd.op = rflg_pkg::OP_IN2;       n_state = S_INT_ST; end
            S_INT_ST: begin o_cmd.op = rflg_pkg::OP_INT_START; n_state = S_INT_W;  end
            S_INT_W:  if (i_stat.div_done) n_state = S_INT_END;
            S_INT_END: begin o_cmd.op = rflg_pkg::OP_INT_END;  n_state = S_EMIT;   end
            S_EMIT: begin
                if (i_stat.suppress) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.op = rflg_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == rflg_pkg::OP_MOD_START || o_cmd.op == rflg_pkg::OP_IDX_START ||
         o_cmd.op == rflg_pkg::OP_INT_START) |-> !i_stat.div_busy)
        else $error("divider started while busy");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == rflg_pkg::OP_EMIT) |-> (i_stat.out_free && !i_stat.suppress))
        else $error("result loaded over a waiting one or while suppressed");

    a_decode_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_accept) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");
endmodule

// ----- sv/random_flicker_level_generator.sv -----
// Sequencing: lock, unlock without emit, ignored commands and silent ticks hold the input
//   until the sequencer is idle again; off emits full scale, on and unlock emit the level
//   (blended or not); a blended non-expiring tick emits the blend; an expiring tick redraws.
// Flow: one beat at a time; the shared restoring divider (modulo, phase index and
//   interpolation) runs up to five divides on an expiring tick.
// Reset: synchronous active low; control and configuration registers take their reset
//   values, enabled comes from the start-enabled bit of the control flags reset value.
module random_flicker_level_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rflg_in_if.sink     in_ch,
    rflg_out_if.source  out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    rflg_pkg::t_dp_cmd  dp_cmd;
    rflg_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               accept;

    // take an input beat only while the sequencer is idle
    assign accept       = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;

    // sequencer: decode command, run the two draws and the blend, hand off result
    rflg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_ready (in_ready)
    );

    // datapath: config, flicker state, wave shaping, divider and the output register
    rflg_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_command         (in_ch.command),
        .i_frame_ms        (in_ch.frame_ms),
        .i_level_random    (in_ch.level_random),
        .i_interval_random (in_ch.interval_random),
        .i_out_ready       (out_ch.ready),
        .o_out_valid       (out_ch.valid),
        .o_intensity       (out_ch.intensity)
    );
endmodule

// ----- bench/random_flicker_level_generator_test.sv -----
module random_flicker_level_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 300;   // long enough for an expiring tick to finish

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  frame_ms;
        logic [15:0] level_random;
        logic [15:0] interval_random;
    } t_flicker_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    rflg_in_if  in_ch ();
    rflg_out_if out_ch ();

    random_flicker_level_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the registers and the generator state.
    bit [15:0] lvl_min, lvl_max, lvl_per, ivl_min, ivl_max, ivl_per;
    bit [3:0]  waves;
    bit [2:0]  flags;
    bit [15:0] prev_lvl, cur_lvl, ivl_len;
    int        countdown_ms;
    bit [31:0] elapsed_ms;
    bit        is_enabled, is_locked;

    bit [15:0] intensity_q[$];   // intensities still owed by the block
    int        fail_count;
    int        beats_sent;
    int        beats_seen;
    int        expirations;
    bit        calm;             // last part of the run: no idling on either side
    bit        pressure_req;
    int        idle_cycles;

    // ---------------- predictor ----------------
    function automatic longint unsigned quarter_wave(longint unsigned x);
        longint unsigned x2, x3, x5, s;
        x2 = (x * x) >> 14;
        x3 = (x2 * x) >> 14;
        x5 = (x3 * x2) >> 14;
        s  = (64'd25736 * x + 64'd1232 * x5 - 64'd10584 * x3) >> 14;
        return (s > 16384) ? 64'd16384 : s;
    endfunction

    // (1 + sin) / 2 in Q15 for a turn fraction in Q0.16
    function automatic longint unsigned wave_weight(bit [15:0] turn);
        bit [1:0]        quad;
        longint unsigned f, s;
        quad = turn[15:14];
        f    = turn[13:0];
        s    = quad[0] ? quarter_wave(16384 - f) : quarter_wave(f);
        return quad[1] ? 16384 - s : 16384 + s;
    endfunction

    function automatic bit [15:0] shaped_draw(bit [15:0] a, bit [15:0] b, bit [1:0] shape,
                                              bit [15:0] period, bit [15:0] rnd);
        longint unsigned lo, hi, span, per, pos, idx, scaled;
        bit [15:0]       turn;
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        span = hi - lo;
        per  = (period == 0) ? 1 : period;
        pos  = elapsed_ms % per;
        idx  = (pos * rflg_pkg::SINE_TABLE_DEPTH) / per;
        turn = 16'((idx * 65536) / rflg_pkg::SINE_TABLE_DEPTH);
        case (shape)
            rflg_pkg::WAVE_COS:    scaled = (span * wave_weight(turn + 16'd16384)) >> 15;
            rflg_pkg::WAVE_SIN:    scaled = (span * wave_weight(turn)) >> 15;
            rflg_pkg::WAVE_SQUARE: return 16'((pos * 2 < per) ? lo : hi);
            default:               scaled = span;
        endcase
        return 16'(lo + (longint'(rnd) * scaled) / 65535);
    endfunction

    function automatic bit [15:0] blended_level();
        longint unsigned len, c;
        if (!flags[0]) return cur_lvl;
        len = ivl_len;
        if (len == 0) return prev_lvl;
        c = (countdown_ms <= 0) ? 0 : countdown_ms;
        if (c > len) c = len;
        return 16'((longint'(prev_lvl) * c + longint'(cur_lvl) * (len - c)) / len);
    endfunction

    function automatic void owe(bit [15:0] v);
        if (!is_locked && !flags[2]) intensity_q.push_back(v);
    endfunction

    function automatic void predict_beat(t_flicker_beat b);
        case (b.command)
            rflg_pkg::CMD_TICK: begin
                if (is_enabled) begin
                    elapsed_ms   += b.frame_ms;
                    countdown_ms -= b.frame_ms;
                    if (countdown_ms <= 0) begin
                        expirations++;
                        prev_lvl = cur_lvl;
                        cur_lvl  = shaped_draw(lvl_min, lvl_max, waves[1:0], lvl_per,
                                               b.level_random);
                        ivl_len  = shaped_draw(ivl_min, ivl_max, waves[3:2], ivl_per,
                                               b.interval_random);
                        countdown_ms = ivl_len;
                        owe(blended_level());
                    end else if (flags[0]) begin
                        owe(blended_level());
                    end
                end
            end
            rflg_pkg::CMD_ON: if (!is_enabled) begin
                is_enabled = 1'b1;
                owe(blended_level());
            end
            rflg_pkg::CMD_OFF: if (is_enabled) begin
                is_enabled = 1'b0;
                owe(16'hFFFF);
            end
            rflg_pkg::CMD_LOCK: is_locked = 1'b1;
            rflg_pkg::CMD_UNLOCK: if (is_locked) begin
                is_locked = 1'b0;
                if (is_enabled) owe(blended_level());
            end
            default: ;
        endcase
    endfunction

    // ---------------- sender ----------------
    task automatic send_beat(t_flicker_beat b, bit no_gap = 1'b0);
        in_ch.valid           <= 1'b1;
        in_ch.command         <= b.command;
        in_ch.frame_ms        <= b.frame_ms;
        in_ch.level_random    <= b.level_random;
        in_ch.interval_random <= b.interval_random;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beat(b);
        beats_sent++;
        // drop valid only when a gap follows; a back-to-back beat keeps it high
        if (!calm && !no_gap && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] cmd, int frame = 0, int lr = 0, int ir = 0);
        t_flicker_beat b;
        b.command = cmd;
        b.frame_ms = frame[9:0];
        b.level_random = lr[15:0];
        b.interval_random = ir[15:0];
        send_beat(b);
    endtask

    // Wait out every owed intensity plus a possible silent expiring tick.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (intensity_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rflg_pkg::CFG_LEVEL_MIN:  lvl_min = val;
            rflg_pkg::CFG_LEVEL_MAX:  lvl_max = val;
            rflg_pkg::CFG_LEVEL_PER:  lvl_per = val;
            rflg_pkg::CFG_IVL_MIN:    ivl_min = val;
            rflg_pkg::CFG_IVL_MAX:    ivl_max = val;
            rflg_pkg::CFG_IVL_PER:    ivl_per = val;
            rflg_pkg::CFG_WAVE_MODES: waves   = val[3:0];
            default:                  flags   = val[2:0];   // enabled stays as it is
        endcase
    endtask

    task automatic write_all(bit [15:0] lmin, bit [15:0] lmax, bit [15:0] lper,
                             bit [15:0] imin, bit [15:0] imax, bit [15:0] iper,
                             bit [3:0] wm, bit [2:0] fl);
        drain_block();
        write_reg(rflg_pkg::CFG_LEVEL_MIN, lmin);
        write_reg(rflg_pkg::CFG_LEVEL_MAX, lmax);
        write_reg(rflg_pkg::CFG_LEVEL_PER, lper);
        write_reg(rflg_pkg::CFG_IVL_MIN, imin);
        write_reg(rflg_pkg::CFG_IVL_MAX, imax);
        write_reg(rflg_pkg::CFG_IVL_PER, iper);
        write_reg(rflg_pkg::CFG_WAVE_MODES, {12'd0, wm});
        write_reg(rflg_pkg::CFG_CTRL_FLAGS, {13'd0, fl});
    endtask

    function automatic t_flicker_beat random_beat();
        t_flicker_beat b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)      b.command = rflg_pkg::CMD_TICK;
        else if (pick < 78) b.command = rflg_pkg::CMD_ON;
        else if (pick < 84) b.command = rflg_pkg::CMD_OFF;
        else if (pick < 89) b.command = rflg_pkg::CMD_LOCK;
        else if (pick < 97) b.command = rflg_pkg::CMD_UNLOCK;
        else                b.command = 3'($urandom_range(5, 7));
        b.frame_ms        = ($urandom_range(0, 9) == 0) ? 10'd1000 : 10'($urandom_range(0, 1000));
        b.level_random    = 16'($urandom);
        b.interval_random = 16'($urandom);
        return b;
    endfunction

    // ---------------- receiver ----------------
    int hold_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cycles  = 0;
        end else if (pressure_req) begin
            // long hold-off: block fills up and must stall its input
            pressure_req = 1'b0;
            hold_cycles  = 400;
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_cycles = $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each intensity beat with the oldest owed value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_seen++;
            if (intensity_q.size() == 0) begin
                $error("intensity: expected none, actual %0d", out_ch.intensity);
                fail_count++;
            end else begin
                bit [15:0] want;
                want = intensity_q.pop_front();
                if (out_ch.intensity !== want) begin
                    $error("intensity: expected %0d, actual %0d", want, out_ch.intensity);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles without any beat moving or configuration write.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_commands();
        // defaults: level 0..65535, interval 0, start enabled
        send_cmd(rflg_pkg::CMD_TICK, 0, 0, 0);    // zero frame still expires a zero countdown
        send_cmd(rflg_pkg::CMD_TICK, 1000, 65535, 65535);
        send_cmd(rflg_pkg::CMD_ON);               // already enabled: nothing
        send_cmd(rflg_pkg::CMD_OFF);              // full scale out
        send_cmd(rflg_pkg::CMD_OFF);              // already off: nothing
        send_cmd(rflg_pkg::CMD_TICK, 500, 1234, 4321);   // disabled tick is dropped
        send_cmd(rflg_pkg::CMD_UNLOCK);           // not locked: nothing
        send_cmd(rflg_pkg::CMD_ON);
        send_cmd(rflg_pkg::CMD_LOCK);
        send_cmd(rflg_pkg::CMD_TICK, 7, 40000, 1);       // suppressed while locked
        send_cmd(rflg_pkg::CMD_OFF);              // suppressed, but disables
        send_cmd(rflg_pkg::CMD_UNLOCK);           // disabled: no intensity
        send_cmd(rflg_pkg::CMD_ON);
        send_cmd(rflg_pkg::CMD_LOCK);
        send_cmd(rflg_pkg::CMD_UNLOCK);           // locked and enabled: current level
        send_cmd(3'd5, 1000, 65535, 65535);
        send_cmd(3'd6);
        send_cmd(3'd7);
        send_cmd(rflg_pkg::CMD_TICK, 1, 32768, 32768);
    endtask

    task automatic test_interpolation();
        // swapped bounds, interpolate, long intervals so ticks land mid-interval
        write_all(16'd60000, 16'd1000, 16'd1, 16'd3000, 16'd500, 16'd65535, 4'd0, 3'b011);
        for (int k = 0; k < 20; k++) send_cmd(rflg_pkg::CMD_TICK, $urandom_range(0, 400),
                                              $urandom, $urandom);
        // equal bounds and suppression of all output
        write_all(16'd777, 16'd777, 16'd0, 16'd0, 16'd0, 16'd0, 4'b1111, 3'b111);
        for (int k = 0; k < 5; k++) send_beat(random_beat());
    endtask

    task automatic test_backpressure();
        write_all(16'd0, 16'd65535, 16'd1000, 16'd0, 16'd200, 16'd1000, 4'b0110, 3'b001);
        send_cmd(rflg_pkg::CMD_UNLOCK);
        send_cmd(rflg_pkg::CMD_ON);
        @(posedge i_clk);
        pressure_req = 1'b1;
        for (int k = 0; k < 12; k++) send_cmd(rflg_pkg::CMD_TICK, $urandom_range(0, 100),
                                              $urandom, $urandom);
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 10; ph++) begin
            bit [15:0] lmin, lmax, imin, imax;
            lmin = (ph == 0) ? 16'd0 : 16'($urandom);
            lmax = (ph == 0) ? 16'hFFFF : ((ph == 1) ? lmin : 16'($urandom));
            imin = (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 1500));
            imax = (ph == 2) ? 16'hFFFE : 16'($urandom_range(0, 2500));
            write_all(lmin, lmax, (ph == 3) ? 16'hFFFF : 16'($urandom_range(1, 6000)),
                      imin, imax, (ph == 4) ? 16'hFFFF : 16'($urandom_range(1, 6000)),
                      (ph < 4) ? 4'($urandom) : 4'(ph * 5), 3'($urandom_range(0, 7)));
            // well-formed opening so the phase runs enabled and unlocked
            send_cmd(rflg_pkg::CMD_UNLOCK);
            send_cmd(rflg_pkg::CMD_ON);
            if (ph == 8) calm = 1'b1;
            for (int k = 0; k < 100; k++) send_beat(random_beat());
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = rflg_pkg::CFG_LEVEL_MIN;
        i_cfg_data            = 16'd0;
        in_ch.valid           = 1'b0;
        in_ch.command         = rflg_pkg::CMD_TICK;
        in_ch.frame_ms        = 10'd0;
        in_ch.level_random    = 16'd0;
        in_ch.interval_random = 16'd0;
        out_ch.ready          = 1'b0;
        calm = 1'b0;
        pressure_req = 1'b0;
        idle_cycles = 0;
        fail_count = 0;
        beats_sent = 0;
        beats_seen = 0;
        expirations = 0;
        lvl_min = 16'd0; lvl_max = 16'hFFFF; lvl_per = 16'd10000;
        ivl_min = 16'd0; ivl_max = 16'd0;    ivl_per = 16'd10000;
        waves = 4'd0; flags = rflg_pkg::CTRL_RESET;
        prev_lvl = 16'd0; cur_lvl = 16'd0; ivl_len = 16'd0;
        countdown_ms = 0; elapsed_ms = 32'd0;
        is_enabled = rflg_pkg::CTRL_RESET[1]; is_locked = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_interpolation();
        test_backpressure();
        test_random_mix();

        drain_block();
        $display("Covered %0d command beats, %0d intensity beats, %0d level redraws,",
                 beats_sent, beats_seen, expirations);
        $display("across all wave shapes, interpolation, lock, suppress and a long stall.");
        if (fail_count == 0 && intensity_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
